>>> sv/rgb_sharpen_4x4_stream_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the RGB 4x4 sharpen stream block.
// Each macro expands to one labeled concurrent assertion on the rising clock
// edge, disabled while reset is high.
// ---------------------------------------------------------------------------
`ifndef RGB_SHARPEN_4X4_STREAM_TOP_ASSERT_SVH
`define RGB_SHARPEN_4X4_STREAM_TOP_ASSERT_SVH

// condition holds at every clock edge
`define RGBS_ASSERT_HOLDS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error(msg);

// consequent holds in the same cycle as the antecedent
`define RGBS_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent holds in the cycle after the antecedent
`define RGBS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/rgbs_pkg.sv
// ---------------------------------------------------------------------------
// rgbs_pkg
// Shared types and constants of the RGB 4x4 sharpen stream block.
// ---------------------------------------------------------------------------
package rgbs_pkg;

   // one RGB pixel, red in the top byte
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pix_type;

   localparam int PIX_W   = 24;
   localparam int LANE_N  = 3;    // rows held in the line store
   localparam int PIX_MAX = 255;

   // window row source: a line store lane (0..2) or the incoming pixel
   typedef logic [1:0] src_type;
   localparam src_type SRC_PIX = 2'd3;

   // control that travels with a pixel into the filter datapath
   typedef struct packed {
      src_type [2:0] src;        // sources of window rows 0..2, row 3 is the pixel
      logic          first_col;  // column 0: window is filled with the new column
      logic          has_norm;   // gives the result for the row above
      logic          has_flush;  // last row: gives the result for this row too
      logic          frame_end;  // last column of the row
   } tap_ctrl_type;

   // result flags leaving the filter datapath
   typedef struct packed {
      logic has_norm;
      logic has_flush;
      logic frame_end;
   } res_ctrl_type;

   // one queued result
   typedef struct packed {
      pix_type pix;
      logic    last_of_run;
      logic    frame_done;
   } rsp_type;

   // result queue
   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_AW    = 3;
   localparam int CNT_W      = 4;

   // filter weights at the reference fraction width
   localparam int Q_REF_BITS = 12;
   localparam int W_CORNER_MAG = 993;
   localparam int W_EDGE_MAG   = 1604;
   localparam int W_INNER_MAG  = 2592;
   localparam int W_CENTER_INT = 7;

   // configuration registers
   typedef enum logic {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_idx_type;

   localparam logic [10:0] WIDTH_RESET  = 11'd1024;
   localparam logic [15:0] HEIGHT_RESET = 16'd1024;

endpackage

>>> sv/rgbs_conv.sv
// ---------------------------------------------------------------------------
// rgbs_conv
// 4x4 window and filter datapath: window shift, class sums, weighting,
// shift and clamp. Gives the normal and the flush result of each pixel.
// ---------------------------------------------------------------------------
module rgbs_conv
   import rgbs_pkg::*;
#(
   parameter int COEF_FRAC_BITS = 12
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     tap_valid,
   input  pix_type                  tap_pix,
   input  pix_type [LANE_N-1:0]     tap_rows,
   input  tap_ctrl_type             tap_ctrl,
   output logic                     res_valid,
   output res_ctrl_type             res_ctrl,
   output pix_type                  res_norm,
   output pix_type                  res_flush
);

   localparam int ACC_W = COEF_FRAC_BITS + 16;
   localparam int WC = -((W_CORNER_MAG * (1 << COEF_FRAC_BITS)) / (1 << Q_REF_BITS));
   localparam int WE = -((W_EDGE_MAG * (1 << COEF_FRAC_BITS)) / (1 << Q_REF_BITS));
   localparam int WI = -((W_INNER_MAG * (1 << COEF_FRAC_BITS)) / (1 << Q_REF_BITS));
   localparam int WK = W_CENTER_INT * (1 << COEF_FRAC_BITS);
   localparam logic signed [ACC_W-1:0] WC_S = ACC_W'(WC);
   localparam logic signed [ACC_W-1:0] WE_S = ACC_W'(WE);
   localparam logic signed [ACC_W-1:0] WI_S = ACC_W'(WI);
   localparam logic signed [ACC_W-1:0] WK_S = ACC_W'(WK);

   // per channel sums of the pixels under each weight class
   typedef struct packed {
      logic [10:0] c;
      logic [10:0] e;
      logic [10:0] i;
      logic [7:0]  k;
   } csum_type;

   function automatic csum_type class_sums(input pix_type [3:0][3:0] win,
                                           input logic flush, input int ch);
      csum_type    s;
      logic [1:0]  row;
      logic [23:0] p;
      logic [10:0] b;
      logic        corner;
      logic        inner;
      s = '0;
      for (int fj = 0; fj < 4; fj++) begin
         for (int fi = 0; fi < 4; fi++) begin
            // flush maps tap rows onto window rows 1, 2, 3, 3
            if (flush) begin
               row = (fj == 0) ? 2'd1 : ((fj == 1) ? 2'd2 : 2'd3);
            end else begin
               row = 2'(fj);
            end
            p      = win[row][2'(fi)];
            b      = 11'(p[(2 - ch) * 8 +: 8]);
            corner = (fj == 0 || fj == 3) && (fi == 0 || fi == 3);
            inner  = (fj == 1 || fj == 2) && (fi == 1 || fi == 2);
            if (corner) begin
               s.c = s.c + b;
            end else if (inner && fj == 2 && fi == 1) begin
               s.k = p[(2 - ch) * 8 +: 8];
            end else if (inner) begin
               s.i = s.i + b;
            end else begin
               s.e = s.e + b;
            end
         end
      end
      return s;
   endfunction

   function automatic logic signed [ACC_W-1:0] weigh(input csum_type s);
      logic signed [ACC_W-1:0] pc;
      logic signed [ACC_W-1:0] pe;
      logic signed [ACC_W-1:0] pi;
      logic signed [ACC_W-1:0] pk;
      pc = $signed(ACC_W'(s.c)) * WC_S;
      pe = $signed(ACC_W'(s.e)) * WE_S;
      pi = $signed(ACC_W'(s.i)) * WI_S;
      pk = $signed(ACC_W'(s.k)) * WK_S;
      return pc + pe + pi + pk;
   endfunction

   // floor shift, then clamp to 0..255
   function automatic logic [7:0] clamp8(input logic signed [ACC_W-1:0] a);
      logic signed [ACC_W-1:0] q;
      logic [7:0]              r;
      q = a >>> COEF_FRAC_BITS;
      if (a < 0) begin
         r = 8'd0;
      end else if (q > $signed(ACC_W'(PIX_MAX))) begin
         r = 8'(PIX_MAX);
      end else begin
         r = q[7:0];
      end
      return r;
   endfunction

   // window: [row][col], col 3 newest
   pix_type [3:0][3:0]      window_ff;
   pix_type [3:0][3:0]      window_in;
   pix_type [3:0]           col_new;

   logic                    s2_valid_ff;
   res_ctrl_type            s2_ctrl_ff;
   logic                    s3_valid_ff;
   res_ctrl_type            s3_ctrl_ff;
   logic                    s4_valid_ff;
   res_ctrl_type            s4_ctrl_ff;

   csum_type                sums_in  [2][3];
   csum_type                sums_ff  [2][3];
   logic signed [ACC_W-1:0] acc_in   [2][3];
   logic signed [ACC_W-1:0] acc_ff   [2][3];

   // new window column from line store lanes and the pixel
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         col_new[k] = (tap_ctrl.src[k] == SRC_PIX) ? tap_pix : tap_rows[tap_ctrl.src[k]];
      end
      col_new[3] = tap_pix;
   end

   // window shift, or fill on the first column of a row
   always_comb begin
      window_in = window_ff;
      if (tap_valid) begin
         for (int k = 0; k < 4; k++) begin
            if (tap_ctrl.first_col) begin
               window_in[k] = {4{col_new[k]}};
            end else begin
               window_in[k][0] = window_ff[k][1];
               window_in[k][1] = window_ff[k][2];
               window_in[k][2] = window_ff[k][3];
               window_in[k][3] = col_new[k];
            end
         end
      end
   end

   // class sums for both row mappings
   always_comb begin
      for (int cv = 0; cv < 2; cv++) begin
         for (int ch = 0; ch < 3; ch++) begin
            sums_in[cv][ch] = class_sums(window_ff, 1'(cv), ch);
         end
      end
   end

   // weighted sums
   always_comb begin
      for (int cv = 0; cv < 2; cv++) begin
         for (int ch = 0; ch < 3; ch++) begin
            acc_in[cv][ch] = weigh(sums_ff[cv][ch]);
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      window_ff  <= window_in;
      s2_ctrl_ff <= '{has_norm:  tap_ctrl.has_norm,
                      has_flush: tap_ctrl.has_flush,
                      frame_end: tap_ctrl.frame_end};
      s3_ctrl_ff <= s2_ctrl_ff;
      s4_ctrl_ff <= s3_ctrl_ff;
      sums_ff    <= sums_in;
      acc_ff     <= acc_in;
   end

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= tap_valid;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   // shift and clamp
   assign res_valid = s4_valid_ff;
   assign res_ctrl  = s4_ctrl_ff;
   assign res_norm  = '{red:   clamp8(acc_ff[0][0]),
                        green: clamp8(acc_ff[0][1]),
                        blue:  clamp8(acc_ff[0][2])};
   assign res_flush = '{red:   clamp8(acc_ff[1][0]),
                        green: clamp8(acc_ff[1][1]),
                        blue:  clamp8(acc_ff[1][2])};

endmodule

>>> sv/rgb_sharpen_4x4_stream_top.sv
// ---------------------------------------------------------------------------
// rgb_sharpen_4x4_stream_top
// RGB 4x4 sharpening filter on a raster pixel stream, one row of lag.
//
//   Port group  Dir  Handshake              Payload
//   req         in   req_valid, req_stall   req_red_in, req_green_in, req_blue_in
//   rsp         out  rsp_valid, rsp_stall   rsp_red_out, rsp_green_out, rsp_blue_out,
//                                           rsp_last_of_run, rsp_frame_done
//   csr         in   csr_valid, csr_ready   csr_index, csr_data
//
// One pixel per clock while req_stall is low. A result passes the stage 1,
// window, class sum and weighted sum registers and then the result queue.
// On the last row of a frame taller than one row every pixel gives two results
// and the single result port drains one per clock.
// Reset clears control only; the line store is not cleared (no clearing pass).
// req_stall rises when more than FIFO_DEPTH-2 results are owed, so results
// waiting on rsp_stall never overflow the queue.
// ---------------------------------------------------------------------------
`include "rgb_sharpen_4x4_stream_top_assert.svh"

module rgb_sharpen_4x4_stream_top
   import rgbs_pkg::*;
#(
   parameter int MAX_WIDTH      = 1024,
   parameter int COEF_FRAC_BITS = 12
) (
   input  logic        clock,
   input  logic        reset,
   // pixel requests
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_red_in,
   input  logic [7:0]  req_green_in,
   input  logic [7:0]  req_blue_in,
   // results
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_red_out,
   output logic [7:0]  rsp_green_out,
   output logic [7:0]  rsp_blue_out,
   output logic        rsp_last_of_run,
   output logic        rsp_frame_done,
   // configuration
   input  logic        csr_valid,
   output logic        csr_ready,
   input  csr_idx_type csr_index,
   input  logic [15:0] csr_data
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int CMP_W = (COL_W + 1 > 11) ? COL_W + 1 : 11;

   // row mod 3 via base-4 digit sum
   function automatic src_type mod3_16(input logic [15:0] v);
      logic [4:0] s;
      logic [3:0] t;
      logic [2:0] u;
      s = '0;
      for (int d = 0; d < 8; d++) begin
         s = s + 5'(v[2 * d +: 2]);
      end
      t = 4'(s[4:2]) + 4'(s[1:0]);
      u = 3'(t[3:2]) + 3'(t[1:0]);
      return (u >= 3'd3) ? 2'(u - 3'd3) : u[1:0];
   endfunction

   logic [10:0]               image_width_ff;
   logic [10:0]               image_width_in;
   logic [15:0]               image_height_ff;
   logic [15:0]               image_height_in;
   logic [COL_W-1:0]          column_index_ff;
   logic [COL_W-1:0]          column_index_in;
   logic [15:0]               row_index_ff;
   logic [15:0]               row_index_in;

   logic                      req_fire;
   pix_type                   req_pix;
   logic [CMP_W-1:0]          width_eff;
   logic [CMP_W-1:0]          col_ext;
   logic [CMP_W-1:0]          x_ext;
   logic [COL_W-1:0]          cur_col;
   logic                      last_col;
   logic [15:0]               height_eff;
   logic [15:0]               cur_row;
   logic                      last_row;
   src_type                   row_lane;
   src_type                   lane_m1;
   src_type                   lane_p1;
   tap_ctrl_type              tap_ctrl;
   logic [1:0]                n_res;

   logic [LANE_N*PIX_W-1:0]   line_mem [MAX_WIDTH];
   pix_type [LANE_N-1:0]      rd_word_ff;
   logic                      s1_valid_ff;
   pix_type                   s1_pix_ff;
   tap_ctrl_type              s1_ctrl_ff;

   logic                      conv_valid;
   res_ctrl_type              conv_ctrl;
   pix_type                   conv_norm;
   pix_type                   conv_flush;

   rsp_type                   fifo_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]        wr_ptr_ff;
   logic [FIFO_AW-1:0]        wr_ptr_in;
   logic [FIFO_AW-1:0]        wr_ptr_nx;
   logic [FIFO_AW-1:0]        rd_ptr_ff;
   logic [FIFO_AW-1:0]        rd_ptr_in;
   logic [CNT_W-1:0]          fifo_cnt_ff;
   logic [CNT_W-1:0]          fifo_cnt_in;
   logic [CNT_W-1:0]          committed_ff;
   logic [CNT_W-1:0]          committed_in;
   logic [1:0]                n_wr;
   rsp_type                   ent0;
   rsp_type                   ent1;
   rsp_type                   head;
   logic                      pop;

   // configuration registers
   assign csr_ready = 1'b1;

   always_comb begin
      image_width_in  = image_width_ff;
      image_height_in = image_height_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  image_width_in  = csr_data[10:0];
            CSR_IMAGE_HEIGHT: image_height_in = csr_data;
            default: ;
         endcase
      end
   end

   // request handshake
   assign req_fire = req_valid && !req_stall;
   assign req_stall = committed_ff > CNT_W'(FIFO_DEPTH - 2);
   assign req_pix  = '{red: req_red_in, green: req_green_in, blue: req_blue_in};

   // effective size and position
   always_comb begin
      col_ext = CMP_W'(column_index_ff);
      if (CMP_W'(image_width_ff) == '0) begin
         width_eff = CMP_W'(1);
      end else if (CMP_W'(image_width_ff) > CMP_W'(MAX_WIDTH)) begin
         width_eff = CMP_W'(MAX_WIDTH);
      end else begin
         width_eff = CMP_W'(image_width_ff);
      end
      x_ext    = (col_ext < width_eff) ? col_ext : width_eff - CMP_W'(1);
      cur_col  = x_ext[COL_W-1:0];
      last_col = (x_ext == width_eff - CMP_W'(1));

      height_eff = (image_height_ff == '0) ? 16'd1 : image_height_ff;
      cur_row    = (row_index_ff < height_eff) ? row_index_ff : height_eff - 16'd1;
      last_row   = (cur_row == height_eff - 16'd1);
   end

   // line store lanes for the three rows above, clamped at the top edge
   always_comb begin
      row_lane = mod3_16(cur_row);
      lane_m1  = (row_lane == 2'd0) ? 2'd2 : row_lane - 2'd1;
      lane_p1  = (row_lane == 2'd2) ? 2'd0 : row_lane + 2'd1;

      tap_ctrl.first_col = (cur_col == '0);
      tap_ctrl.has_norm  = (cur_row != '0);
      tap_ctrl.has_flush = last_row;
      tap_ctrl.frame_end = last_col;
      if (cur_row == '0) begin
         tap_ctrl.src = {SRC_PIX, SRC_PIX, SRC_PIX};
      end else begin
         tap_ctrl.src[2] = lane_m1;
         tap_ctrl.src[1] = (cur_row >= 16'd2) ? lane_p1 : 2'd0;
         tap_ctrl.src[0] = (cur_row >= 16'd3) ? row_lane : 2'd0;
      end
      n_res = 2'(tap_ctrl.has_norm) + 2'(tap_ctrl.has_flush);
   end

   // next position
   always_comb begin
      column_index_in = column_index_ff;
      row_index_in    = row_index_ff;
      if (req_fire) begin
         if (last_col) begin
            column_index_in = '0;
            row_index_in    = last_row ? 16'd0 : cur_row + 16'd1;
         end else begin
            column_index_in = cur_col + COL_W'(1);
            row_index_in    = cur_row;
         end
      end
   end

   // line store: read all lanes, write this row's lane, read returns old data
   always_ff @(posedge clock) begin
      rd_word_ff <= line_mem[cur_col];
      for (int l = 0; l < LANE_N; l++) begin
         if (req_fire && (row_lane == 2'(l))) begin
            line_mem[cur_col][l * PIX_W +: PIX_W] <= req_pix;
         end
      end
   end

   // stage 1 pixel and control
   always_ff @(posedge clock) begin
      s1_pix_ff  <= req_pix;
      s1_ctrl_ff <= tap_ctrl;
   end

   // filter datapath
   rgbs_conv #(
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_conv (
      .clock     (clock),
      .reset     (reset),
      .tap_valid (s1_valid_ff),
      .tap_pix   (s1_pix_ff),
      .tap_rows  (rd_word_ff),
      .tap_ctrl  (s1_ctrl_ff),
      .res_valid (conv_valid),
      .res_ctrl  (conv_ctrl),
      .res_norm  (conv_norm),
      .res_flush (conv_flush)
   );

   // result queue write side
   always_comb begin
      n_wr = conv_valid ? (2'(conv_ctrl.has_norm) + 2'(conv_ctrl.has_flush)) : 2'd0;
      ent1 = '{pix: conv_flush, last_of_run: 1'b1, frame_done: conv_ctrl.frame_end};
      if (conv_ctrl.has_norm) begin
         ent0 = '{pix: conv_norm, last_of_run: !conv_ctrl.has_flush, frame_done: 1'b0};
      end else begin
         ent0 = ent1;
      end
      wr_ptr_nx = wr_ptr_ff + FIFO_AW'(1);
   end

   always_ff @(posedge clock) begin
      if (n_wr != 2'd0) begin
         fifo_ff[wr_ptr_ff] <= ent0;
      end
      if (n_wr == 2'd2) begin
         fifo_ff[wr_ptr_nx] <= ent1;
      end
   end

   // result queue read side
   assign head            = fifo_ff[rd_ptr_ff];
   assign rsp_valid       = (fifo_cnt_ff != '0);
   assign rsp_red_out     = head.pix.red;
   assign rsp_green_out   = head.pix.green;
   assign rsp_blue_out    = head.pix.blue;
   assign rsp_last_of_run = head.last_of_run;
   assign rsp_frame_done  = head.frame_done;
   assign pop             = rsp_valid && !rsp_stall;

   // pointers and counts
   always_comb begin
      wr_ptr_in    = wr_ptr_ff + FIFO_AW'(n_wr);
      rd_ptr_in    = rd_ptr_ff + FIFO_AW'(pop);
      fifo_cnt_in  = fifo_cnt_ff + CNT_W'(n_wr) - CNT_W'(pop);
      committed_in = committed_ff + (req_fire ? CNT_W'(n_res) : '0) - CNT_W'(pop);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= WIDTH_RESET;
         image_height_ff <= HEIGHT_RESET;
         column_index_ff <= '0;
         row_index_ff    <= '0;
         s1_valid_ff     <= 1'b0;
         wr_ptr_ff       <= '0;
         rd_ptr_ff       <= '0;
         fifo_cnt_ff     <= '0;
         committed_ff    <= '0;
      end else begin
         image_width_ff  <= image_width_in;
         image_height_ff <= image_height_in;
         column_index_ff <= column_index_in;
         row_index_ff    <= row_index_in;
         s1_valid_ff     <= req_fire;
         wr_ptr_ff       <= wr_ptr_in;
         rd_ptr_ff       <= rd_ptr_in;
         fifo_cnt_ff     <= fifo_cnt_in;
         committed_ff    <= committed_in;
      end
   end

   // checks
   `RGBS_ASSERT_HOLDS(a_queue_within_owed, clock, reset,
      fifo_cnt_ff <= committed_ff, "queued results exceed owed results")
   `RGBS_ASSERT_HOLDS(a_owed_bound, clock, reset,
      committed_ff <= CNT_W'(FIFO_DEPTH), "owed results exceed queue depth")
   `RGBS_ASSERT_IMPLIES(a_pair_has_room, clock, reset,
      conv_valid && conv_ctrl.has_norm && conv_ctrl.has_flush,
      fifo_cnt_ff <= CNT_W'(FIFO_DEPTH - 2), "no room for a result pair")
   `RGBS_ASSERT_IMPLIES(a_frame_done_last, clock, reset,
      rsp_valid && rsp_frame_done, rsp_last_of_run, "frame end not on last result")

endmodule

>>> verif/rgb_sharpen_4x4_stream_top_tb.sv
// ---------------------------------------------------------------------------
// rgb_sharpen_4x4_stream_top_tb
// Streams RGB frames through the 4x4 sharpen block and compares every
// result pixel, field by field, against a cycle-free model of the filter
// kept in a scoreboard class. Covers degenerate and clamped image sizes,
// size changes in the middle of a frame, saturation at both ends, random
// idling on both channels and a long result hold-off that backs up input.
// ---------------------------------------------------------------------------
module rgb_sharpen_4x4_stream_top_tb
   import rgbs_pkg::*;
();

   localparam int MAX_W       = 1024;
   localparam int FRAC        = 12;
   localparam int RAND_ITEMS  = 1550;
   localparam int CALM_ITEMS  = 150;
   localparam int SETTLE      = 16;     // cycles past the last result
   localparam int HOLD_CYCLES = 200;    // long result hold-off
   localparam int RUN_LIMIT   = 8000000;

   typedef enum int {PIX_RANDOM, PIX_EXTREME, PIX_MIXED} pix_mix_type;

   // -------------------------------------------------------------------------
   // Filter model and queue of owed result pixels
   // -------------------------------------------------------------------------
   class sharpen_checker;
      pix_type     line_mem [3][MAX_W];
      pix_type     win [4][4];
      longint      tap [4][4];
      int          col_pos;
      int          row_pos;
      logic [10:0] width_reg;
      logic [15:0] height_reg;
      rsp_type     owed_pixels [$];
      int          errors;

      function new();
         bit edge_r, edge_c;
         int mag;
         for (int fj = 0; fj < 4; fj++) begin
            for (int fi = 0; fi < 4; fi++) begin
               edge_r = (fj == 0 || fj == 3);
               edge_c = (fi == 0 || fi == 3);
               if (edge_r && edge_c) mag = W_CORNER_MAG;
               else if (edge_r || edge_c) mag = W_EDGE_MAG;
               else mag = W_INNER_MAG;
               // Q12 magnitudes rescaled, truncated toward zero
               if (FRAC >= Q_REF_BITS) tap[fj][fi] = -(longint'(mag) <<< (FRAC - Q_REF_BITS));
               else tap[fj][fi] = -(longint'(mag) / (longint'(1) <<< (Q_REF_BITS - FRAC)));
               win[fj][fi] = '0;
            end
         end
         tap[2][1] = longint'(W_CENTER_INT) <<< FRAC;
         col_pos    = 0;
         row_pos    = 0;
         width_reg  = WIDTH_RESET;
         height_reg = HEIGHT_RESET;
         errors     = 0;
      endfunction

      function void write_reg(csr_idx_type idx, logic [15:0] data);
         if (idx == CSR_IMAGE_WIDTH) width_reg = data[10:0];
         else height_reg = data;
      endfunction

      function bit at_frame_start();
         return col_pos == 0 && row_pos == 0;
      endfunction

      // floor shift, then saturate to a byte
      function logic [7:0] clamp_byte(longint acc);
         longint q;
         q = acc >>> FRAC;
         if (q < 0) return 8'd0;
         if (q > PIX_MAX) return 8'(PIX_MAX);
         return q[7:0];
      endfunction

      // flush repeats the newest window row in place of the missing row below
      function pix_type filter_window(bit flush);
         longint  acc_r, acc_g, acc_b;
         int      src;
         pix_type p, o;
         acc_r = 0;
         acc_g = 0;
         acc_b = 0;
         for (int fj = 0; fj < 4; fj++) begin
            src = flush ? ((fj == 3) ? 3 : fj + 1) : fj;
            for (int fi = 0; fi < 4; fi++) begin
               p = win[src][fi];
               acc_r += longint'(p.red) * tap[fj][fi];
               acc_g += longint'(p.green) * tap[fj][fi];
               acc_b += longint'(p.blue) * tap[fj][fi];
            end
         end
         o.red   = clamp_byte(acc_r);
         o.green = clamp_byte(acc_g);
         o.blue  = clamp_byte(acc_b);
         return o;
      endfunction

      // accepted pixel: advance the window and queue the results it causes
      function void take_pixel(pix_type pix);
         int      w, h, x, r, j;
         pix_type v;
         rsp_type res;
         w = width_reg;
         if (w == 0) w = 1;
         if (w > MAX_W) w = MAX_W;
         h = height_reg;
         if (h == 0) h = 1;
         x = (col_pos < w) ? col_pos : w - 1;
         r = (row_pos < h) ? row_pos : h - 1;

         for (int k = 0; k < 4; k++) begin
            j = r - 3 + k;
            if (j < 0) j = 0;
            v = (j == r) ? pix : line_mem[j % 3][x];
            if (x == 0) begin
               for (int i = 0; i < 4; i++) win[k][i] = v;
            end else begin
               for (int i = 0; i < 3; i++) win[k][i] = win[k][i + 1];
               win[k][3] = v;
            end
         end
         line_mem[r % 3][x] = pix;

         // row above, then the last row itself when this is the last row
         if (r >= 1) begin
            res.pix         = filter_window(1'b0);
            res.last_of_run = !(r + 1 >= h);
            res.frame_done  = 1'b0;
            owed_pixels.push_back(res);
         end
         if (r + 1 >= h) begin
            res.pix         = filter_window(1'b1);
            res.last_of_run = 1'b1;
            res.frame_done  = (x + 1 >= w);
            owed_pixels.push_back(res);
         end

         if (x + 1 >= w) begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
         end else begin
            col_pos = x + 1;
            row_pos = r;
         end
      endfunction

      function void field_check(string name, logic [7:0] exp_v, logic [7:0] act_v);
         if (act_v !== exp_v) begin
            errors++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
         end
      endfunction

      function void check_pixel(rsp_type got);
         rsp_type exp_r;
         if (owed_pixels.size() == 0) begin
            errors++;
            $display("%0t: unexpected result: expected none, actual %h", $time, got);
         end else begin
            exp_r = owed_pixels.pop_front();
            field_check("red_out", exp_r.pix.red, got.pix.red);
            field_check("green_out", exp_r.pix.green, got.pix.green);
            field_check("blue_out", exp_r.pix.blue, got.pix.blue);
            field_check("last_of_run", 8'(exp_r.last_of_run), 8'(got.last_of_run));
            field_check("frame_done", 8'(exp_r.frame_done), 8'(got.frame_done));
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Signals and block under test
   // -------------------------------------------------------------------------
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_red_in = '0;
   logic [7:0]  req_green_in = '0;
   logic [7:0]  req_blue_in = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_red_out;
   logic [7:0]  rsp_green_out;
   logic [7:0]  rsp_blue_out;
   logic        rsp_last_of_run;
   logic        rsp_frame_done;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   csr_idx_type csr_index = CSR_IMAGE_WIDTH;
   logic [15:0] csr_data = '0;

   sharpen_checker sb = new();

   bit          calm = 1'b0;            // no idling on either side
   bit          rsp_hold_asked = 1'b0;
   int          send_odds = 1;
   int          items_sent = 0;
   logic [10:0] cur_w = WIDTH_RESET;
   logic [15:0] cur_h = HEIGHT_RESET;

   rgb_sharpen_4x4_stream_top #(
      .MAX_WIDTH      (MAX_W),
      .COEF_FRAC_BITS (FRAC)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_red_in      (req_red_in),
      .req_green_in    (req_green_in),
      .req_blue_in     (req_blue_in),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_red_out     (rsp_red_out),
      .rsp_green_out   (rsp_green_out),
      .rsp_blue_out    (rsp_blue_out),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_frame_done  (rsp_frame_done),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always #10 clock = ~clock;

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------
   function automatic pix_type make_pixel(pix_mix_type mix);
      pix_type p;
      logic [7:0] ch [3];
      for (int i = 0; i < 3; i++) begin
         case (mix)
            PIX_RANDOM: begin
               ch[i] = 8'($urandom_range(0, 255));
            end
            PIX_EXTREME: begin
               ch[i] = $urandom_range(0, 1) ? 8'd255 : 8'd0;
            end
            default: begin
               case ($urandom_range(0, 2))
                  0: ch[i] = 8'd0;
                  1: ch[i] = 8'd255;
                  default: ch[i] = 8'($urandom_range(0, 255));
               endcase
            end
         endcase
      end
      p.red   = ch[0];
      p.green = ch[1];
      p.blue  = ch[2];
      return p;
   endfunction

   // one pixel request, optionally after an idle burst; valid stays high
   task automatic send_pixel(input pix_type pix);
      int gap;
      gap = 0;
      if (!calm && send_odds != 0 && $urandom_range(1, send_odds * 4) == 1)
         gap = $urandom_range(1, 7);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_red_in   <= pix.red;
      req_green_in <= pix.green;
      req_blue_in  <= pix.blue;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.take_pixel(pix);
      items_sent++;
      if (items_sent % 100 == 0) send_odds = $urandom_range(0, 3);
   endtask

   // send pixels until the model is back at the top left corner
   task automatic finish_frame(input pix_mix_type mix);
      do send_pixel(make_pixel(mix)); while (!sb.at_frame_start());
   endtask

   // stop requests and let every owed result out, plus pipeline slack
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.owed_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // write both size registers; unused width data bits carry noise
   task automatic program_size(input logic [10:0] w, input logic [15:0] h);
      logic [15:0] wdata;
      wdata = {5'($urandom), w};
      csr_valid <= 1'b1;
      csr_index <= CSR_IMAGE_WIDTH;
      csr_data  <= wdata;
      do @(posedge clock); while (csr_ready !== 1'b1);
      sb.write_reg(CSR_IMAGE_WIDTH, wdata);
      csr_index <= CSR_IMAGE_HEIGHT;
      csr_data  <= h;
      do @(posedge clock); while (csr_ready !== 1'b1);
      sb.write_reg(CSR_IMAGE_HEIGHT, h);
      csr_valid <= 1'b0;
      cur_w = w;
      cur_h = h;
   endtask

   // -------------------------------------------------------------------------
   // Result side: checking, random stall bursts, long hold-off on request
   // -------------------------------------------------------------------------
   initial begin : result_side
      int      stall_left;
      int      hold_left;
      int      cyc;
      int      odds;
      rsp_type got;
      stall_left = 0;
      hold_left  = 0;
      cyc        = 0;
      odds       = 1;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            got.pix.red     = rsp_red_out;
            got.pix.green   = rsp_green_out;
            got.pix.blue    = rsp_blue_out;
            got.last_of_run = rsp_last_of_run;
            got.frame_done  = rsp_frame_done;
            sb.check_pixel(got);
         end
         cyc++;
         if (cyc % 200 == 0) odds = $urandom_range(0, 3);
         if (rsp_hold_asked) begin
            hold_left = HOLD_CYCLES;
            rsp_hold_asked = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (calm || odds == 0) begin
            rsp_stall <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if ($urandom_range(1, odds * 4) == 1) begin
            stall_left = $urandom_range(0, 6);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin : main_seq
      int          rand_start;
      int          target;
      int          ew, eh, limit, cut_at, pick;
      bit          pressure_done, wide_done, reconf, cut;
      logic [10:0] w_val;
      logic [15:0] h_val;
      pix_type     p;
      pix_mix_type mix;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // zero width and zero height both act as a single pixel
      program_size(11'd0, 16'd0);
      p = '1;
      send_pixel(p);
      p = '0;
      send_pixel(p);
      wait_drained();

      // small checkerboard: first row silent, last row doubled, both clamps
      program_size(11'd4, 16'd3);
      for (int i = 0; i < 12; i++) begin
         p = ((i + i / 4) % 2) ? '1 : '0;
         send_pixel(p);
      end
      wait_drained();

      // stop mid-row of a tall frame, then shrink so the position lies
      // past both the new width and the new height
      program_size(11'd4, 16'hFFFF);
      repeat (10) send_pixel(make_pixel(PIX_MIXED));
      wait_drained();
      program_size(11'd2, 16'd2);
      send_pixel(make_pixel(PIX_EXTREME));
      wait_drained();

      // random frames
      pressure_done = 1'b0;
      wide_done     = 1'b0;
      rand_start    = items_sent;
      target        = RAND_ITEMS - items_sent;
      reconf        = 1'b1;
      while (items_sent - rand_start < target) begin
         mix = pix_mix_type'($urandom_range(0, 2));
         if (items_sent - rand_start >= target - CALM_ITEMS) calm = 1'b1;

         if (!pressure_done && items_sent - rand_start > 300) begin
            // results back up behind a held receiver until input stalls
            wait_drained();
            program_size(11'd16, 16'd5);
            rsp_hold_asked = 1'b1;
            finish_frame(mix);
            pressure_done = 1'b1;
         end else if (!wide_done && items_sent - rand_start > 400) begin
            // oversize width acts as the maximum line length
            wait_drained();
            program_size(11'h7FF, $urandom_range(0, 1) ? 16'd1 : 16'd0);
            finish_frame(mix);
            wide_done = 1'b1;
         end else begin
            if (reconf || $urandom_range(0, 1)) begin
               pick = $urandom_range(0, 19);
               if (pick < 14) w_val = 11'($urandom_range(1, 12));
               else if (pick < 16) w_val = 11'd0;
               else if (pick < 18) w_val = 11'($urandom_range(13, 40));
               else if (pick == 18) w_val = 11'(MAX_W);
               else w_val = 11'($urandom_range(MAX_W + 1, 2047));
               pick = $urandom_range(0, 19);
               if (pick < 14) h_val = 16'($urandom_range(1, 5));
               else if (pick < 16) h_val = 16'd0;
               else if (pick < 18) h_val = 16'($urandom_range(6, 8));
               else if (pick == 18) h_val = 16'hFFFF;
               else h_val = 16'($urandom_range(9, 65534));
               wait_drained();
               program_size(w_val, h_val);
            end
            reconf = 1'b0;

            ew = (cur_w == 0) ? 1 : ((cur_w > MAX_W) ? MAX_W : cur_w);
            eh = (cur_h == 0) ? 1 : cur_h;
            cut = (ew > 40 || eh > 8 || $urandom_range(0, 3) == 0);
            limit = ((ew < 40) ? ew : 40) * ((eh < 4) ? eh : 4);
            if (cut && limit >= 2) begin
               // part of a frame, then shrink the size under the position
               cut_at = $urandom_range(1, limit - 1);
               repeat (cut_at) send_pixel(make_pixel(mix));
               wait_drained();
               program_size(11'($urandom_range(1, (ew < 12) ? ew : 12)),
                            16'($urandom_range(1, 5)));
            end
            finish_frame(mix);
         end
      end

      // drain and settle
      wait_drained();
      if (sb.errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // run limit
   initial begin : watchdog
      #(RUN_LIMIT);
      $display("Regression FAIL");
      $finish;
   end

endmodule
